>>> sv/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue_unit.
package spq_pkg;

  localparam int PRIO_W            = 5;
  localparam int DATA_W            = 32;
  localparam int FILL_W            = 5;
  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted shift-register queue: holds a priority and payload.
// Depends on spq_pkg.
module spq_cell #(
  parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                       clk,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic                       occupied,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [PAYLOAD_WIDTH-1:0]   new_payload,
  input  logic                       left_keep,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [PAYLOAD_WIDTH-1:0]   left_payload,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  logic [PAYLOAD_WIDTH-1:0]   right_payload,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [PAYLOAD_WIDTH-1:0]   payload,
  output logic                       keep
);

  logic [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_WIDTH-1:0]   payload_r, payload_nxt;

  // Entry stays put on insert when it ranks equal or above the new one.
  assign keep = occupied && (prio_r >= new_prio);

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (ctrl.enq && !keep) begin
      if (left_keep) begin
        prio_nxt    = new_prio;
        payload_nxt = new_payload;
      end else begin
        prio_nxt    = left_prio;
        payload_nxt = left_payload;
      end
    end else if (ctrl.deq) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

>>> sv/stable_priority_queue_unit.sv
// Stable priority queue: top level with handshake, fill count and cell chain.
// Depends on spq_pkg and spq_cell.
//
// Each input beat is one command: enqueue (in_tuser = 0) or dequeue (in_tuser = 1),
// and each produces exactly one output beat in the cycle after acceptance. A new
// beat is taken every cycle as long as the result register is empty or being
// drained, so the sustained rate is one beat per clock. All DEPTH cells compare
// the incoming priority against their own in the same cycle and shift in one
// step, so the rate does not depend on DEPTH. Entries of equal priority leave in
// arrival order. An enqueue into a full queue is dropped and reported as full; a
// dequeue of an empty queue reports empty. fill_level is the entry count after
// the command, low five bits.
module stable_priority_queue_unit #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] prio, [36:5] payload, rest zero
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [4:0] out_prio, [36:5] out_payload, [41:37] fill_level
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = PAYLOAD_WIDTH;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic                       accept;
  logic                       mode;
  logic [spq_pkg::PRIO_W-1:0] new_prio;
  logic [spq_pkg::DATA_W-1:0] in_payload;
  logic [PW-1:0]              new_payload;
  logic [PW+spq_pkg::DATA_W-1:0] in_ext;

  logic [CW-1:0] count_r, count_nxt;
  logic          is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
  logic [PW-1:0]              cell_payload [DEPTH];
  logic [DEPTH-1:0]           cell_keep;

  logic                       out_valid_r;
  spq_pkg::status_t           out_status_r, status_nxt;
  logic [spq_pkg::PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [spq_pkg::DATA_W-1:0] out_payload_r, out_payload_nxt;
  logic [spq_pkg::FILL_W-1:0] out_fill_r;
  logic [spq_pkg::DATA_W+PW-1:0] head_ext;
  logic [CW+spq_pkg::FILL_W-1:0] fill_ext;

  assign in_tready  = rst_n && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign mode       = in_tuser;
  assign new_prio   = in_tdata[4:0];
  assign in_payload = in_tdata[36:5];
  assign in_ext     = {{PW{1'b0}}, in_payload};
  assign new_payload = in_ext[PW-1:0];

  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  assign ctrl.enq = accept && (mode == spq_pkg::MODE_ENQ) && !is_full;
  assign ctrl.deq = accept && (mode == spq_pkg::MODE_DEQ) && !is_empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic                       l_keep;
      logic [spq_pkg::PRIO_W-1:0] l_prio, r_prio;
      logic [PW-1:0]              l_payload, r_payload;

      if (i == 0) begin : g_head
        assign l_keep    = 1'b0;
        assign l_prio    = new_prio;
        assign l_payload = new_payload;
      end else begin : g_body
        assign l_keep    = cell_keep[i-1];
        assign l_prio    = cell_prio[i-1];
        assign l_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_prio    = cell_prio[i];
        assign r_payload = cell_payload[i];
      end else begin : g_mid
        assign r_prio    = cell_prio[i+1];
        assign r_payload = cell_payload[i+1];
      end

      spq_cell #(
        .PAYLOAD_WIDTH(PW)
      ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .occupied     (IDX < count_r),
        .new_prio     (new_prio),
        .new_payload  (new_payload),
        .left_keep    (l_keep),
        .left_prio    (l_prio),
        .left_payload (l_payload),
        .right_prio   (r_prio),
        .right_payload(r_payload),
        .prio         (cell_prio[i]),
        .payload      (cell_payload[i]),
        .keep         (cell_keep[i])
      );
    end
  endgenerate

  assign head_ext = {{spq_pkg::DATA_W{1'b0}}, cell_payload[0]};

  always_comb begin
    count_nxt       = count_r;
    out_prio_nxt    = '0;
    out_payload_nxt = '0;
    if (mode == spq_pkg::MODE_ENQ) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        status_nxt = spq_pkg::ST_ENQ;
        count_nxt  = count_r + CW'(1);
      end
    end else if (is_empty) begin
      status_nxt = spq_pkg::ST_EMPTY;
    end else begin
      status_nxt      = spq_pkg::ST_DEQ;
      count_nxt       = count_r - CW'(1);
      out_prio_nxt    = cell_prio[0];
      out_payload_nxt = head_ext[spq_pkg::DATA_W-1:0];
    end
  end

  assign fill_ext = {{spq_pkg::FILL_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_nxt;
      out_prio_r    <= out_prio_nxt;
      out_payload_r <= out_payload_nxt;
      out_fill_r    <= fill_ext[spq_pkg::FILL_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_fill_r, out_payload_r, out_prio_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted command left no result");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == spq_pkg::MODE_DEQ && is_empty) |=>
      (out_tuser == spq_pkg::ST_EMPTY && $stable(count_r)))
    else $error("empty dequeue misreported");

  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == spq_pkg::MODE_ENQ && is_full) |=>
      (out_tuser == spq_pkg::ST_FULL && $stable(count_r)))
    else $error("full enqueue misreported");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head entries out of priority order");
`endif

endmodule

>>> bench/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stable_priority_queue_unit: directed and random command streams
// with a sorted-queue predictor; depends on spq_pkg and the unit under test.
module stable_priority_queue_unit_tb;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    spq_pkg::status_t status;
    logic [4:0]       prio;
    logic [31:0]      payload;
    logic [4:0]       fill;
  } queue_result_t;

  class spq_scoreboard;
    logic [spq_pkg::PRIO_W-1:0] held_prio[QDEPTH];
    logic [spq_pkg::DATA_W-1:0] held_payload[QDEPTH];
    int                held = 0;
    queue_result_t     pending_q[$];
    int                errors = 0;

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_command(input logic mode, input logic [4:0] p, input logic [31:0] d);
      queue_result_t r;
      int pos;
      r.status  = spq_pkg::ST_ENQ;
      r.prio    = '0;
      r.payload = '0;
      if (mode == spq_pkg::MODE_ENQ) begin
        if (held >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && held_prio[pos] >= p) pos++;
          for (int i = held; i > pos; i--) begin
            held_prio[i]    = held_prio[i-1];
            held_payload[i] = held_payload[i-1];
          end
          held_prio[pos]    = p;
          held_payload[pos] = d;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.status  = spq_pkg::ST_DEQ;
          r.prio    = held_prio[0];
          r.payload = held_payload[0];
          for (int i = 1; i < held; i++) begin
            held_prio[i-1]    = held_prio[i];
            held_payload[i-1] = held_payload[i];
          end
          held--;
        end
      end
      r.fill = held[4:0];
      pending_q.push_back(r);
    endfunction

    task check_result(input logic [1:0] st, input logic [4:0] p, input logic [31:0] d,
                      input logic [4:0] f);
      queue_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat status=%0d prio=%0d payload=%h fill=%0d",
                         st, p, d, f));
      end else begin
        r = pending_q.pop_front();
        if (st !== r.status)
          report($sformatf("status got %0d exp %0d", st, r.status));
        if (p !== r.prio)
          report($sformatf("prio got %0d exp %0d", p, r.prio));
        if (d !== r.payload)
          report($sformatf("payload got %h exp %h", d, r.payload));
        if (f !== r.fill)
          report($sformatf("fill_level got %0d exp %0d", f, r.fill));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [4:0] prio, [36:5] payload, rest zero
  logic        in_tuser = 1'b0; // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [4:0] out_prio, [36:5] out_payload, [41:37] fill_level
  logic [1:0]  out_tuser;       // [1:0] status

  spq_scoreboard sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;

  stable_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // beat monitor: note commands first, then check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_command(in_tuser, in_tdata[4:0], in_tdata[36:5]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[4:0], out_tdata[36:5], out_tdata[41:37]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stable_priority_queue_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result-side ready: random runs and gaps, plus a long hold-off on request
  initial begin
    int run;
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_tready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = pick_gap(rx_quiet);
      if (gap > 0 && !rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [4:0] p, input logic [31:0] d);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, d, p};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_payload(output logic [31:0] d);
    case ($urandom_range(0, 9))
      0: d = 32'h0000_0000;
      1: d = 32'hFFFF_FFFF;
      default: d = $urandom;
    endcase
  endtask

  initial begin
    int sent;
    int phase_len;
    int enq_pct;
    int prio_base;
    bit narrow;
    logic mode;
    logic [4:0] p;
    logic [31:0] d;

    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, extremes, ties, fill to full, overflow, partial drain
    send_beat(spq_pkg::MODE_DEQ, 5'd0, 32'h0);
    send_beat(spq_pkg::MODE_ENQ, 5'd31, 32'hFFFF_FFFF);
    send_beat(spq_pkg::MODE_ENQ, 5'd0, 32'h0000_0000);
    send_beat(spq_pkg::MODE_ENQ, 5'd15, 32'h1234_5678);
    send_beat(spq_pkg::MODE_ENQ, 5'd15, 32'hA5A5_A5A5);
    send_beat(spq_pkg::MODE_ENQ, 5'd31, 32'h0000_0001);
    send_beat(spq_pkg::MODE_ENQ, 5'd0, 32'h8000_0000);
    for (int k = 0; k < 10; k++) begin
      random_payload(d);
      send_beat(spq_pkg::MODE_ENQ, 5'((k * 7) % 32), d);
    end
    send_beat(spq_pkg::MODE_ENQ, 5'd31, 32'hDEAD_BEEF);
    repeat (6) send_beat(spq_pkg::MODE_DEQ, 5'($urandom), $urandom);
    wait_drained();

    sent = 0;
    while (sent < 1400) begin
      phase_len = $urandom_range(30, 100);
      case ($urandom_range(0, 4))
        0: enq_pct = 95;
        1: enq_pct = 80;
        2: enq_pct = 50;
        3: enq_pct = 20;
        default: enq_pct = 5;
      endcase
      narrow    = ($urandom_range(0, 2) == 0);
      prio_base = $urandom_range(0, 29);
      tx_quiet  = ($urandom_range(0, 4) == 0);
      rx_quiet  = ($urandom_range(0, 4) == 0);
      if (sent >= 400 && sent < 500) begin
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
      end
      for (int k = 0; k < phase_len; k++) begin
        mode = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::MODE_ENQ : spq_pkg::MODE_DEQ;
        p = narrow ? 5'(prio_base + $urandom_range(0, 2)) : 5'($urandom_range(0, 31));
        random_payload(d);
        send_beat(mode, p, d);
        sent++;
      end
      if (sent >= 800 && sent < 900 || $urandom_range(0, 5) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("stable_priority_queue_unit verification clean");
    end else begin
      $display("stable_priority_queue_unit verification failed");
    end
    $finish;
  end

endmodule
